FILE: src/dss_pkg.sv
// ----------------------------------------------------------------------------
// dss_pkg
// Shared types and codes for the dual stack block: request codes, result
// status codes and the command word passed from the front end to the back end.
// ----------------------------------------------------------------------------
`default_nettype none

package dss_pkg;

  // Request codes as seen on the input channel
  localparam logic [2:0] REQ_PUSH_LOW  = 3'd0;
  localparam logic [2:0] REQ_PUSH_HIGH = 3'd1;
  localparam logic [2:0] REQ_POP_LOW   = 3'd2;
  localparam logic [2:0] REQ_POP_HIGH  = 3'd3;
  localparam logic [2:0] REQ_SHOW_LOW  = 3'd4;
  localparam logic [2:0] REQ_SHOW_HIGH = 3'd5;

  // Result status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_OVERFLOW = 2'd1;
  localparam logic [1:0] ST_EMPTY    = 2'd2;

  localparam int unsigned DATA_W = 32;

  // Decoded operation
  typedef enum logic [1:0] {
    OP_PUSH = 2'd0,
    OP_POP  = 2'd1,
    OP_SHOW = 2'd2
  } op_t;

  // Which stack a command targets
  typedef enum logic {
    SIDE_LOW  = 1'b0,
    SIDE_HIGH = 1'b1
  } side_t;

  // Command word held in the queue between front and back
  typedef struct packed {
    op_t                       op;
    side_t                     side;
    logic signed [DATA_W-1:0]  value;
  } cmd_t;

  // Queue handshake toward the back end
  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } cmdq_t;

endpackage

`default_nettype wire

FILE: src/dual_stack_shared_store_core.sv
// ----------------------------------------------------------------------------
// dual_stack_shared_store_core
// Two LIFO stacks in one shared store: the low stack grows up from entry 0,
// the high stack down from the top entry. Push, pop and show requests.
//
//   channel  direction  handshake            payload
//   in_      input      in_valid / in_stall  in_req_type, in_value
//   out_     output     out_valid/out_stall  out_status, out_data, out_last
//
// A push, an overflow or an empty result is answered from the idle state; a pop
// reads the store, then emits the result. A show emits one entry per store read,
// paced by the single read port of the store.
// The front queue holds two requests, so input is taken while the back end
// works or the result register is stalled. Reset clears both stack counts;
// the store needs no clearing pass. Unused request codes are taken and dropped.
// ----------------------------------------------------------------------------
`default_nettype none

module dual_stack_shared_store_core
  import dss_pkg::*;
#(
  parameter int unsigned DEPTH = 32
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_valid,
  output logic                           in_stall,
  input  wire logic [2:0]                in_req_type,
  input  wire logic signed [DATA_W-1:0]  in_value,
  output logic                           out_valid,
  input  wire logic                      out_stall,
  output logic [1:0]                     out_status,
  output logic signed [DATA_W-1:0]       out_data,
  output logic                           out_last
);

  cmdq_t q;
  logic  q_pop;

  // Accept and decode
  dss_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_req_type (in_req_type),
    .in_value    (in_value),
    .q_out       (q),
    .q_pop       (q_pop)
  );

  // Execute and emit results
  dss_back #(
    .DEPTH (DEPTH)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_in       (q),
    .q_pop      (q_pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_status (out_status),
    .out_data   (out_data),
    .out_last   (out_last)
  );

endmodule

`default_nettype wire

FILE: src/dss_ram.sv
// ----------------------------------------------------------------------------
// dss_ram
// Generic single-write, single-read RAM with registered read data. Read data
// holds while no read is issued.
// ----------------------------------------------------------------------------
`default_nettype none

module dss_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 32
) (
  input  wire logic                       clk,
  input  wire logic                       we,
  input  wire logic [$clog2(DEPTH)-1:0]   waddr,
  input  wire logic [WIDTH-1:0]           wdata,
  input  wire logic                       re,
  input  wire logic [$clog2(DEPTH)-1:0]   raddr,
  output logic      [WIDTH-1:0]           rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem_r[raddr];
    end
  end

endmodule

`default_nettype wire

FILE: src/dss_front.sv
// ----------------------------------------------------------------------------
// dss_front
// Input side: accepts transactions, decodes the request code into a command
// and holds it in a two-entry queue for the back end. Unused request codes
// are accepted and dropped.
// ----------------------------------------------------------------------------
`default_nettype none

module dss_front
  import dss_pkg::*;
(
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_valid,
  output logic                           in_stall,
  input  wire logic [2:0]                in_req_type,
  input  wire logic signed [DATA_W-1:0]  in_value,
  output cmdq_t                          q_out,
  input  wire logic                      q_pop
);

  cmd_t       q_mem_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  cmd_t       dec_cmd;
  logic       dec_ok;
  logic       push;

  // Request decode
  always_comb begin
    dec_cmd.value = in_value;
    dec_cmd.op    = OP_PUSH;
    dec_cmd.side  = SIDE_LOW;
    dec_ok        = 1'b1;
    unique case (in_req_type)
      REQ_PUSH_LOW:  begin dec_cmd.op = OP_PUSH; dec_cmd.side = SIDE_LOW;  end
      REQ_PUSH_HIGH: begin dec_cmd.op = OP_PUSH; dec_cmd.side = SIDE_HIGH; end
      REQ_POP_LOW:   begin dec_cmd.op = OP_POP;  dec_cmd.side = SIDE_LOW;  end
      REQ_POP_HIGH:  begin dec_cmd.op = OP_POP;  dec_cmd.side = SIDE_HIGH; end
      REQ_SHOW_LOW:  begin dec_cmd.op = OP_SHOW; dec_cmd.side = SIDE_LOW;  end
      REQ_SHOW_HIGH: begin dec_cmd.op = OP_SHOW; dec_cmd.side = SIDE_HIGH; end
      default:       dec_ok = 1'b0;
    endcase
  end

  // Queue control
  assign in_stall    = (cnt_r == 2'd2);
  assign push        = in_valid && !in_stall && dec_ok;
  assign q_out.valid = (cnt_r != 2'd0);
  assign q_out.cmd   = q_mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push  ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = q_pop ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + {1'b0, push} - {1'b0, q_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Queue storage, no reset
  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wr_ptr_r] <= dec_cmd;
    end
  end

endmodule

`default_nettype wire

FILE: src/dss_back.sv
// ----------------------------------------------------------------------------
// dss_back
// Execution side: owns the two stack counts and the shared store, carries out
// one command at a time and drives the registered result channel. Shows walk
// the stack one entry per cycle while the result channel is not stalled.
// ----------------------------------------------------------------------------
`default_nettype none

module dss_back
  import dss_pkg::*;
#(
  parameter int unsigned DEPTH = 32
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire cmdq_t                     q_in,
  output logic                           q_pop,
  output logic                           out_valid,
  input  wire logic                      out_stall,
  output logic [1:0]                     out_status,
  output logic signed [DATA_W-1:0]       out_data,
  output logic                           out_last
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_DATA = 2'b10
  } state_t;

  state_t                    state_r, state_nxt;
  logic [CW-1:0]             low_cnt_r, low_cnt_nxt;
  logic [CW-1:0]             high_cnt_r, high_cnt_nxt;
  logic [AW-1:0]             addr_r, addr_nxt;
  side_t                     side_r, side_nxt;
  logic                      last_r, last_nxt;
  logic                      out_valid_r, out_valid_nxt;
  logic [1:0]                out_status_r, out_status_nxt;
  logic signed [DATA_W-1:0]  out_data_r, out_data_nxt;
  logic                      out_last_r, out_last_nxt;

  logic                      ram_we, ram_re;
  logic [AW-1:0]             ram_waddr, ram_raddr;
  logic [DATA_W-1:0]         ram_rdata;

  logic [CW:0]               total;
  logic                      full;
  logic                      out_free;
  logic [AW-1:0]             next_addr;
  logic                      sel_empty;
  logic [AW-1:0]             pop_addr;
  logic [AW-1:0]             show_addr;

  localparam logic [AW-1:0] ADDR_TOP = AW'(DEPTH - 1);

  assign total    = {1'b0, low_cnt_r} + {1'b0, high_cnt_r};
  assign full     = (total >= (CW+1)'(DEPTH));
  assign out_free = !out_valid_r || !out_stall;

  // Per-side addresses of the current command
  always_comb begin
    if (q_in.cmd.side == SIDE_LOW) begin
      sel_empty = (low_cnt_r == '0);
      pop_addr  = AW'(low_cnt_r - CW'(1));
      show_addr = AW'(low_cnt_r - CW'(1));
    end else begin
      sel_empty = (high_cnt_r == '0);
      pop_addr  = AW'(CW'(DEPTH) - high_cnt_r);
      show_addr = AW'(CW'(DEPTH) - high_cnt_r);
    end
  end

  // Next entry of a show walk
  assign next_addr = (side_r == SIDE_LOW) ? addr_r - AW'(1) : addr_r + AW'(1);

  // Sequencer
  always_comb begin
    state_nxt      = state_r;
    low_cnt_nxt    = low_cnt_r;
    high_cnt_nxt   = high_cnt_r;
    addr_nxt       = addr_r;
    side_nxt       = side_r;
    last_nxt       = last_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_status_nxt = out_status_r;
    out_data_nxt   = out_data_r;
    out_last_nxt   = out_last_r;
    q_pop          = 1'b0;
    ram_we         = 1'b0;
    ram_waddr      = AW'(low_cnt_r);
    ram_re         = 1'b0;
    ram_raddr      = pop_addr;

    unique case (state_r)
      S_IDLE: begin
        if (q_in.valid && out_free) begin
          q_pop    = 1'b1;
          side_nxt = q_in.cmd.side;
          unique case (q_in.cmd.op)
            OP_PUSH: begin
              out_valid_nxt  = 1'b1;
              out_data_nxt   = '0;
              out_last_nxt   = 1'b1;
              if (full) begin
                out_status_nxt = ST_OVERFLOW;
              end else begin
                out_status_nxt = ST_OK;
                ram_we         = 1'b1;
                if (q_in.cmd.side == SIDE_LOW) begin
                  ram_waddr   = AW'(low_cnt_r);
                  low_cnt_nxt = low_cnt_r + CW'(1);
                end else begin
                  ram_waddr    = AW'(CW'(DEPTH - 1) - high_cnt_r);
                  high_cnt_nxt = high_cnt_r + CW'(1);
                end
              end
            end
            OP_POP, OP_SHOW: begin
              if (sel_empty) begin
                out_valid_nxt  = 1'b1;
                out_status_nxt = ST_EMPTY;
                out_data_nxt   = '0;
                out_last_nxt   = 1'b1;
              end else if (q_in.cmd.op == OP_POP) begin
                ram_re    = 1'b1;
                ram_raddr = pop_addr;
                last_nxt  = 1'b1;
                state_nxt = S_DATA;
                if (q_in.cmd.side == SIDE_LOW) begin
                  low_cnt_nxt = low_cnt_r - CW'(1);
                end else begin
                  high_cnt_nxt = high_cnt_r - CW'(1);
                end
              end else begin
                ram_re    = 1'b1;
                ram_raddr = show_addr;
                addr_nxt  = show_addr;
                last_nxt  = (q_in.cmd.side == SIDE_LOW) ? (show_addr == '0)
                                                        : (show_addr == ADDR_TOP);
                state_nxt = S_DATA;
              end
            end
            default: begin
              q_pop = 1'b1;
            end
          endcase
        end
      end
      S_DATA: begin
        // Emit the word read from the store, fetch the next one of a show
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = ST_OK;
          out_data_nxt   = $signed(ram_rdata);
          out_last_nxt   = last_r;
          if (last_r) begin
            state_nxt = S_IDLE;
          end else begin
            ram_re    = 1'b1;
            ram_raddr = next_addr;
            addr_nxt  = next_addr;
            last_nxt  = (side_r == SIDE_LOW) ? (next_addr == '0)
                                             : (next_addr == ADDR_TOP);
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      low_cnt_r   <= '0;
      high_cnt_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      low_cnt_r   <= low_cnt_nxt;
      high_cnt_r  <= high_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    addr_r       <= addr_nxt;
    side_r       <= side_nxt;
    last_r       <= last_nxt;
    out_status_r <= out_status_nxt;
    out_data_r   <= out_data_nxt;
    out_last_r   <= out_last_nxt;
  end

  // Shared store
  dss_ram #(
    .WIDTH (DATA_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (DATA_W'($unsigned(q_in.cmd.value))),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;
  assign out_data   = out_data_r;
  assign out_last   = out_last_r;

  // Checks
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    total <= (CW+1)'(DEPTH))
    else $error("stack counts exceed store depth");

  a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> state_r == S_IDLE)
    else $error("queue popped while a command is in progress");

  a_we_idle: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (state_r == S_IDLE) && !ram_re)
    else $error("store write outside of idle");

  a_push_count: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |=> total == $past(total) + (CW+1)'(1))
    else $error("successful push did not grow the stacks by one");

  a_data_read: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) && (state_nxt == S_DATA) |-> ram_re)
    else $error("data state entered without a store read");

endmodule

`default_nettype wire

FILE: bench/dual_stack_shared_store_core_tb.sv
// ----------------------------------------------------------------------------
// dual_stack_shared_store_core_tb
// Self-checking bench for the two-stacks-in-one-store core. Requests are
// driven over the valid/stall input channel while a scoreboard class keeps
// its own copy of the store and both stack depths, predicts every result
// transaction and compares the output channel field by field. Stimulus runs
// from a directed opening through fill, drain and mixed episodes with
// random idling on both channels.
// ----------------------------------------------------------------------------

import dss_pkg::*;

typedef struct packed {
  logic [1:0]               status;
  logic signed [DATA_W-1:0] data;
  logic                     last;
} stack_result_t;

// Predicts result transactions of both stacks and checks the DUT output
class dual_stack_board #(int unsigned DEPTH = 32);
  logic signed [DATA_W-1:0] mirror [DEPTH];
  int unsigned   low_depth;
  int unsigned   high_depth;
  stack_result_t pending[$];
  int unsigned   mismatches;
  int unsigned   checked;
  int unsigned   overflows;
  int unsigned   empties;
  int unsigned   longest_run;
  int unsigned   pushes;
  int unsigned   pops;
  int unsigned   shows;
  int unsigned   ignored;

  function void queue_result(logic [1:0] st, logic signed [DATA_W-1:0] d, logic l);
    stack_result_t r;
    r.status = st;
    r.data   = d;
    r.last   = l;
    pending.push_back(r);
    if (st == ST_OVERFLOW) overflows++;
    if (st == ST_EMPTY) empties++;
  endfunction

  // Update the mirrored state for one accepted request and queue its results
  function void note_request(logic [2:0] req, logic signed [DATA_W-1:0] val);
    int unsigned run;
    run = 0;
    case (req)
      REQ_PUSH_LOW, REQ_PUSH_HIGH: begin
        pushes++;
        if (low_depth + high_depth >= DEPTH) begin
          queue_result(ST_OVERFLOW, '0, 1'b1);
        end else begin
          if (req == REQ_PUSH_LOW) begin
            mirror[low_depth] = val;
            low_depth++;
          end else begin
            high_depth++;
            mirror[DEPTH - high_depth] = val;
          end
          queue_result(ST_OK, '0, 1'b1);
        end
      end
      REQ_POP_LOW: begin
        pops++;
        if (low_depth == 0) begin
          queue_result(ST_EMPTY, '0, 1'b1);
        end else begin
          low_depth--;
          queue_result(ST_OK, mirror[low_depth], 1'b1);
        end
      end
      REQ_POP_HIGH: begin
        pops++;
        if (high_depth == 0) begin
          queue_result(ST_EMPTY, '0, 1'b1);
        end else begin
          queue_result(ST_OK, mirror[DEPTH - high_depth], 1'b1);
          high_depth--;
        end
      end
      REQ_SHOW_LOW: begin
        shows++;
        if (low_depth == 0) begin
          queue_result(ST_EMPTY, '0, 1'b1);
        end else begin
          // top of the low stack first, entry 0 last
          for (int unsigned i = low_depth; i > 0; i--) begin
            queue_result(ST_OK, mirror[i-1], i == 1);
          end
          run = low_depth;
        end
      end
      REQ_SHOW_HIGH: begin
        shows++;
        if (high_depth == 0) begin
          queue_result(ST_EMPTY, '0, 1'b1);
        end else begin
          // top of the high stack first, top entry of the store last
          for (int unsigned i = DEPTH - high_depth; i < DEPTH; i++) begin
            queue_result(ST_OK, mirror[i], i == DEPTH - 1);
          end
          run = high_depth;
        end
      end
      default: ignored++;
    endcase
    if (run > longest_run) longest_run = run;
  endfunction

  // Compare one accepted result transaction with the oldest prediction
  function void check_result(logic [1:0] st, logic signed [DATA_W-1:0] d, logic l);
    stack_result_t want;
    checked++;
    if (pending.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("[%0t] unexpected result: status %0d data %0d last %0b",
                 $realtime, st, d, l);
      return;
    end
    want = pending.pop_front();
    if (want.status !== st || want.data !== d || want.last !== l) begin
      mismatches++;
      if (mismatches <= 10)
        $display({"[%0t] mismatch: expected status %0d data %0d last %0b,",
                  " got status %0d data %0d last %0b"},
                 $realtime, want.status, want.data, want.last, st, d, l);
    end
  endfunction
endclass

module dual_stack_shared_store_core_tb;

  localparam int unsigned STORE_DEPTH = 32;
  localparam int unsigned ITEM_TARGET = 300;
  localparam int unsigned TAIL_ITEMS  = 40;

  // Request codes with no meaning; the core takes and drops them
  localparam logic [2:0] REQ_SPARE_0 = 3'd6;
  localparam logic [2:0] REQ_SPARE_1 = 3'd7;

  logic                     clk         = 1'b0;
  logic                     rst_n       = 1'b0;
  logic                     in_valid    = 1'b0;
  logic                     in_stall;
  logic [2:0]               in_req_type = REQ_PUSH_LOW;
  logic signed [DATA_W-1:0] in_value    = '0;
  logic                     out_valid;
  logic                     out_stall   = 1'b0;
  logic [1:0]               out_status;
  logic signed [DATA_W-1:0] out_data;
  logic                     out_last;

  dual_stack_board #(STORE_DEPTH) board;

  int unsigned sent       = 0;
  bit          quiet_tail = 1'b0;
  bit          calm       = 1'b0;
  int unsigned stall_left = 0;

  dual_stack_shared_store_core #(
    .DEPTH(STORE_DEPTH)
  ) u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_req_type(in_req_type),
    .in_value   (in_value),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_status (out_status),
    .out_data   (out_data),
    .out_last   (out_last)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // Receiver backpressure: random bursts of stall
  always @(posedge clk) begin
    if (stall_left != 0) begin
      out_stall  <= 1'b1;
      stall_left <= stall_left - 1;
    end else if (!quiet_tail && !calm && $urandom_range(0, 5) == 0) begin
      out_stall  <= 1'b1;
      stall_left <= $urandom_range(0, 3);
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Result monitor
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      board.check_result(out_status, out_data, out_last);
  end

  // Random words half of the time, the extremes, zero and -1 the other half
  function automatic logic signed [DATA_W-1:0] pick_value();
    case ($urandom_range(0, 7))
      0:       return 32'sh7fff_ffff;
      1:       return 32'sh8000_0000;
      2:       return '0;
      3:       return -1;
      default: return $urandom;
    endcase
  endfunction

  // Drive one request transaction and wait for it to be taken
  task automatic send_request(input logic [2:0] req, input logic signed [DATA_W-1:0] val);
    if (!quiet_tail && !calm && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_req_type <= req;
    in_value    <= val;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    board.note_request(req, val);
    if (req <= REQ_SHOW_HIGH) sent++;
    quiet_tail = (sent + TAIL_ITEMS >= ITEM_TARGET);
  endtask

  // Hold the input channel idle until every predicted result is out
  task automatic wait_for_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (board.pending.size() != 0) @(posedge clk);
  endtask

  // Push until the store is full, try one or two more, then show both stacks
  task automatic fill_store(input int side_mode);
    logic [2:0] req;
    while (board.low_depth + board.high_depth < STORE_DEPTH) begin
      if (side_mode == 0)      req = REQ_PUSH_LOW;
      else if (side_mode == 1) req = REQ_PUSH_HIGH;
      else                     req = $urandom_range(0, 1) ? REQ_PUSH_HIGH : REQ_PUSH_LOW;
      send_request(req, pick_value());
    end
    repeat ($urandom_range(1, 2))
      send_request($urandom_range(0, 1) ? REQ_PUSH_HIGH : REQ_PUSH_LOW, pick_value());
    send_request(REQ_SHOW_LOW, pick_value());
    send_request(REQ_SHOW_HIGH, pick_value());
  endtask

  // Pop both stacks down to empty, with an occasional show, then pop an empty stack
  task automatic drain_store();
    while (board.low_depth + board.high_depth != 0) begin
      case ($urandom_range(0, 9))
        0:       send_request(REQ_SHOW_LOW, pick_value());
        1:       send_request(REQ_SHOW_HIGH, pick_value());
        2, 3, 4, 5: send_request(REQ_POP_LOW, pick_value());
        default: send_request(REQ_POP_HIGH, pick_value());
      endcase
    end
    send_request($urandom_range(0, 1) ? REQ_POP_HIGH : REQ_POP_LOW, pick_value());
  endtask

  // Random mix of pushes, pops, shows and unused codes, weighted toward pushes so the stacks stay populated
  task automatic mixed_traffic(input int unsigned count);
    int unsigned r;
    repeat (count) begin
      r = $urandom_range(0, 19);
      if (r < 9)
        send_request($urandom_range(0, 1) ? REQ_PUSH_HIGH : REQ_PUSH_LOW, pick_value());
      else if (r < 14)
        send_request($urandom_range(0, 1) ? REQ_POP_HIGH : REQ_POP_LOW, pick_value());
      else if (r < 17)
        send_request($urandom_range(0, 1) ? REQ_SHOW_HIGH : REQ_SHOW_LOW, pick_value());
      else if (r == 17)
        send_request($urandom_range(0, 1) ? REQ_SPARE_1 : REQ_SPARE_0, pick_value());
      else
        send_request(REQ_PUSH_LOW, pick_value());
    end
  endtask

  // Run limit
  initial begin
    #(20 * 400_000);
    $display("Timeout: %0d results still outstanding", board.pending.size());
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    board = new();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty stacks, extreme words, show order, ignored codes
    send_request(REQ_POP_LOW, 32'sh1234_5678);
    send_request(REQ_POP_HIGH, '0);
    send_request(REQ_SHOW_LOW, '0);
    send_request(REQ_SHOW_HIGH, -1);
    send_request(REQ_PUSH_LOW, 32'sh7fff_ffff);
    send_request(REQ_PUSH_LOW, 32'sh8000_0000);
    send_request(REQ_PUSH_HIGH, '0);
    send_request(REQ_PUSH_HIGH, -1);
    send_request(REQ_PUSH_LOW, 32'sh0000_0001);
    send_request(REQ_SHOW_LOW, '0);
    send_request(REQ_SHOW_HIGH, '0);
    send_request(REQ_POP_LOW, '0);
    send_request(REQ_POP_HIGH, '0);
    send_request(REQ_SPARE_0, 32'sh5555_aaaa);
    send_request(REQ_SPARE_1, 32'shaaaa_5555);
    send_request(REQ_POP_HIGH, '0);
    send_request(REQ_POP_HIGH, '0);
    send_request(REQ_POP_LOW, '0);
    send_request(REQ_POP_LOW, '0);
    send_request(REQ_SHOW_LOW, '0);
    send_request(REQ_POP_LOW, '0);
    wait_for_results();

    // Longest runs: each stack alone holding the whole store
    fill_store(0);
    wait_for_results();
    drain_store();
    fill_store(1);
    drain_store();

    while (sent < ITEM_TARGET) begin
      calm = ($urandom_range(0, 3) == 0);
      case ($urandom_range(0, 3))
        0: begin
          fill_store(2);
          wait_for_results();
        end
        1:       drain_store();
        default: mixed_traffic($urandom_range(10, 30));
      endcase
    end

    // Let everything drain, then watch for stray results
    in_valid <= 1'b0;
    @(posedge clk);
    while (board.pending.size() != 0) @(posedge clk);
    repeat (2 * STORE_DEPTH + 8) @(posedge clk);

    $display("Ran %0d requests: %0d pushes, %0d pops, %0d shows, %0d ignored codes.",
             sent + board.ignored, board.pushes, board.pops, board.shows, board.ignored);
    $display("Checked %0d results: %0d overflows, %0d empty, longest show run %0d.",
             board.checked, board.overflows, board.empties, board.longest_run);
    if (board.mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("%0d mismatches", board.mismatches);
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
